// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the RTL. The checks are clocked on i_clk and
// are switched off while i_rst_n is low. Defining ASSERT_OFF empties them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("assertion failed");

`else

`define ASSERT_SAME(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== design/lsct_pkg.sv =====
// ----------------------------------------------------------------------------
// lsct_pkg
// Types and constants of the sector cache tag unit.
// ----------------------------------------------------------------------------
package lsct_pkg;

    localparam int SLOTS        = 8;
    localparam int SLOT_BITS    = $clog2(SLOTS);
    localparam int SECTOR_BITS  = 24;
    localparam int ADDR_BITS    = SECTOR_BITS + 1;
    localparam int OFFSET_BITS  = 8;
    localparam int STATUS_BITS  = 2;

    localparam logic [OFFSET_BITS-1:0] READ_OFFSET_RESET = OFFSET_BITS'(150);

    localparam logic CMD_CLEAR  = 1'b0;
    localparam logic CMD_ACCESS = 1'b1;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_HIT     = 2'd0,
        ST_FILLED  = 2'd1,
        ST_FAILED  = 2'd2,
        ST_CLEARED = 2'd3
    } t_status;

    // One position of the use list: the physical slot it names, with that
    // slot's tag and valid bit.
    typedef struct packed {
        logic [SLOT_BITS-1:0]   slot;
        logic [SECTOR_BITS-1:0] tag;
        logic                   valid;
    } t_entry;

    // Per-cell update controls.
    typedef struct packed {
        logic clear;       // drop the valid bit (clear command)
        logic shift;       // take the neighbour's entry
        logic invalidate;  // drop the valid bit (failed fetch)
    } t_cell_ctrl;

endpackage

// ===== design/lru_sector_cache_tags_unit.sv =====
// ----------------------------------------------------------------------------
// lru_sector_cache_tags_unit
// Tag store and least recently used replacement for a fully associative
// sector cache, built as a row of list cells.
// ----------------------------------------------------------------------------
//
//  Channel   | Direction | Handshake              | Payload
//  ----------+-----------+------------------------+----------------------------
//  request   | in        | start high, busy low   | i_command, i_sector,
//            |           |                        | i_read_ok
//  result    | out       | o_strobe, one cycle    | o_status, o_slot, o_fetch,
//            |           |                        | o_device_address
//  config    | in        | i_cfg_valid, o_cfg_ready | i_cfg_data (read offset)
//
// A request accepted at one clock edge produces its result in the next cycle,
// with o_strobe high for a single cycle. A new request may follow every
// cycle: the whole update is a single pass through the cell row, so busy
// stays low. The receiver cannot stall the result. After reset the use list
// holds slot p at position p, every slot is invalid and the read offset is
// 150; no clearing pass is needed because the valid bits reset at once.
// ----------------------------------------------------------------------------
module lru_sector_cache_tags_unit
    import lsct_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   i_command,
    input  logic [SECTOR_BITS-1:0] i_sector,
    input  logic                   i_read_ok,
    output logic                   o_strobe,
    output logic [STATUS_BITS-1:0] o_status,
    output logic [SLOT_BITS-1:0]   o_slot,
    output logic                   o_fetch,
    output logic [ADDR_BITS-1:0]   o_device_address,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [OFFSET_BITS-1:0] i_cfg_data
);

`include "assert_macros.svh"

    // ------------------------------------------------------------------
    // Request handshake and configuration register.
    // ------------------------------------------------------------------
    logic accept;
    logic is_access;
    logic is_clear;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;
    assign is_access   = accept && (i_command == CMD_ACCESS);
    assign is_clear    = accept && (i_command == CMD_CLEAR);

    logic [OFFSET_BITS-1:0] r_read_offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_read_offset <= READ_OFFSET_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_read_offset <= i_cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // The cell row. Position 0 is the least recently used end. Each cell
    // is fed the entry of its right-hand neighbour; the last cell is fed
    // the promoted entry, which becomes the most recently used.
    // ------------------------------------------------------------------
    t_entry     entries [SLOTS];
    t_entry     right   [SLOTS];
    t_cell_ctrl ctrl    [SLOTS];
    logic [SLOTS-1:0] hit_vec;
    t_entry     tail;

    for (genvar i = 0; i < SLOTS; i++) begin : g_cell
        if (i == SLOTS - 1) begin : g_tail
            assign right[i] = tail;
        end else begin : g_inner
            assign right[i] = entries[i+1];
        end

        lsct_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_reset_slot (SLOT_BITS'(i)),
            .i_sector     (i_sector),
            .i_ctrl       (ctrl[i]),
            .i_right      (right[i]),
            .o_entry      (entries[i]),
            .o_match      (hit_vec[i])
        );
    end

    // ------------------------------------------------------------------
    // Victim and promotion selection.
    // On a hit the matching position is chosen (valid tags are unique, so
    // at most one cell matches). On a miss the first invalid position in
    // list order is chosen, or position 0 when every slot is valid.
    // ------------------------------------------------------------------
    logic             hit;
    logic [SLOTS-1:0] first_inv;
    logic [SLOTS-1:0] sel;
    logic [SLOTS-1:0] from_sel;
    t_entry           moved;
    logic             any_inv;

    assign hit = |hit_vec;

    always_comb begin
        any_inv   = 1'b0;
        first_inv = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (!entries[i].valid && !any_inv) begin
                first_inv[i] = 1'b1;
                any_inv      = 1'b1;
            end
        end
    end

    always_comb begin
        priority if (hit) begin
            sel = hit_vec;
        end else if (any_inv) begin
            sel = first_inv;
        end else begin
            sel    = '0;
            sel[0] = 1'b1;
        end
    end

    // The selected entry, and the positions at or beyond it, which shift
    // one place towards the least recently used end on a promotion.
    always_comb begin
        moved    = '0;
        from_sel = '0;
        for (int i = 0; i < SLOTS; i++) begin
            moved = moved | (sel[i] ? entries[i] : '0);
        end
        from_sel[0] = sel[0];
        for (int i = 1; i < SLOTS; i++) begin
            from_sel[i] = sel[i] || from_sel[i-1];
        end
    end

    always_comb begin
        tail       = moved;
        tail.valid = 1'b1;
        tail.tag   = hit ? moved.tag : i_sector;
    end

    logic promote;
    logic failed;

    assign promote = is_access && (hit || i_read_ok);
    assign failed  = is_access && !hit && !i_read_ok;

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            ctrl[i].clear      = is_clear;
            ctrl[i].shift      = promote && from_sel[i];
            ctrl[i].invalidate = failed && sel[i];
        end
    end

    // ------------------------------------------------------------------
    // Result register. The result is shown for one cycle after the
    // request was taken.
    // ------------------------------------------------------------------
    logic                   r_strobe;
    t_status                r_status;
    logic [SLOT_BITS-1:0]   r_slot;
    logic                   r_fetch;
    logic [ADDR_BITS-1:0]   r_addr;
    t_status                n_status;
    logic [SLOT_BITS-1:0]   n_slot;
    logic                   n_fetch;
    logic [ADDR_BITS-1:0]   n_addr;

    always_comb begin
        n_slot   = '0;
        n_fetch  = 1'b0;
        n_addr   = '0;
        priority if (i_command == CMD_CLEAR) begin
            n_status = ST_CLEARED;
        end else if (hit) begin
            n_status = ST_HIT;
            n_slot   = moved.slot;
        end else begin
            n_status = i_read_ok ? ST_FILLED : ST_FAILED;
            n_slot   = moved.slot;
            n_fetch  = 1'b1;
            n_addr   = ADDR_BITS'(i_sector) + ADDR_BITS'(r_read_offset);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
            r_slot   <= n_slot;
            r_fetch  <= n_fetch;
            r_addr   <= n_addr;
        end
    end

    assign o_strobe         = r_strobe;
    assign o_status         = r_status;
    assign o_slot           = r_slot;
    assign o_fetch          = r_fetch;
    assign o_device_address = r_addr;

    // ------------------------------------------------------------------
    // Checks.
    // ------------------------------------------------------------------
    // Every physical slot must appear in the use list exactly once.
    logic [SLOTS-1:0] slot_seen;

    always_comb begin
        slot_seen = '0;
        for (int i = 0; i < SLOTS; i++) begin
            slot_seen[entries[i].slot] = 1'b1;
        end
    end

    `ASSERT_SAME(a_list_is_permutation, 1'b1, &slot_seen)
    `ASSERT_NEXT(a_result_follows_request, accept, o_strobe)
    `ASSERT_NEXT(a_hit_moves_to_mru, is_access && hit, (o_status == ST_HIT) && (entries[SLOTS-1].slot == o_slot))
    `ASSERT_SAME(a_fetch_only_on_miss, o_strobe && o_fetch, (o_status == ST_FILLED) || (o_status == ST_FAILED))

endmodule

// ===== design/lsct_cell.sv =====
// ----------------------------------------------------------------------------
// lsct_cell
// One position of the use list. Compares its tag with the requested sector
// and, on a promotion, takes over the entry of its right-hand neighbour.
// ----------------------------------------------------------------------------
module lsct_cell
    import lsct_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [SLOT_BITS-1:0]   i_reset_slot,
    input  logic [SECTOR_BITS-1:0] i_sector,
    input  t_cell_ctrl             i_ctrl,
    input  t_entry                 i_right,
    output t_entry                 o_entry,
    output logic                   o_match
);

    t_entry r_entry;
    t_entry n_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.clear) begin
            n_entry.valid = 1'b0;
        end else if (i_ctrl.shift) begin
            n_entry = i_right;
        end else if (i_ctrl.invalidate) begin
            n_entry.valid = 1'b0;
        end
    end

    // The tag needs no reset: it is only looked at behind its valid bit.
    always_ff @(posedge i_clk) begin
        r_entry.tag <= n_entry.tag;
        if (!i_rst_n) begin
            r_entry.slot  <= i_reset_slot;
            r_entry.valid <= 1'b0;
        end else begin
            r_entry.slot  <= n_entry.slot;
            r_entry.valid <= n_entry.valid;
        end
    end

    assign o_entry = r_entry;
    assign o_match = r_entry.valid && (r_entry.tag == i_sector);

endmodule

// ===== tb/lru_sector_cache_tags_unit_checker.sv =====
// ----------------------------------------------------------------------------
// lru_sector_cache_tags_unit_checker
// Watches the request, result and configuration channels of the sector cache
// tag unit. It keeps its own use list, tags and valid bits, predicts the
// result of every accepted request and compares each strobed result with the
// oldest prediction.
// ----------------------------------------------------------------------------
module lru_sector_cache_tags_unit_checker
    import lsct_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic                   i_busy,
    input  logic                   i_command,
    input  logic [SECTOR_BITS-1:0] i_sector,
    input  logic                   i_read_ok,
    input  logic                   i_strobe,
    input  logic [STATUS_BITS-1:0] i_status,
    input  logic [SLOT_BITS-1:0]   i_slot,
    input  logic                   i_fetch,
    input  logic [ADDR_BITS-1:0]   i_device_address,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [OFFSET_BITS-1:0] i_cfg_data,
    output int                     o_fail_count,
    output int                     o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_status                status;
        logic [SLOT_BITS-1:0]   slot;
        logic                   fetch;
        logic [ADDR_BITS-1:0]   device_address;
    } t_sector_result;

    // Position 0 is the least recently used end of the list.
    logic [SLOT_BITS-1:0]   use_list [SLOTS];
    logic [SECTOR_BITS-1:0] held_tag [SLOTS];
    logic                   held_valid [SLOTS];
    logic [OFFSET_BITS-1:0] read_offset;
    t_sector_result         expected_results [$];
    int                     failures = 0;

    function automatic void move_to_recent(int pos);
        logic [SLOT_BITS-1:0] moved;
        moved = use_list[pos];
        for (int p = pos; p < SLOTS - 1; p++) begin
            use_list[p] = use_list[p + 1];
        end
        use_list[SLOTS - 1] = moved;
    endfunction

    function automatic t_sector_result look_up_sector(logic command,
                                                      logic [SECTOR_BITS-1:0] sector,
                                                      logic read_ok);
        t_sector_result       res;
        int                   hit_pos;
        int                   chosen;
        logic [SLOT_BITS-1:0] phys;
        res = '0;
        if (command == CMD_CLEAR) begin
            for (int s = 0; s < SLOTS; s++) begin
                held_valid[s] = 1'b0;
            end
            res.status = ST_CLEARED;
            return res;
        end
        hit_pos = -1;
        for (int p = 0; p < SLOTS; p++) begin
            if (held_valid[use_list[p]] && held_tag[use_list[p]] == sector) begin
                hit_pos = p;
            end
        end
        if (hit_pos >= 0) begin
            res.status = ST_HIT;
            res.slot   = use_list[hit_pos];
            move_to_recent(hit_pos);
            return res;
        end
        // Scanning downwards leaves the first invalid position; with none
        // invalid the least recently used position 0 remains.
        chosen = 0;
        for (int p = SLOTS - 1; p >= 0; p--) begin
            if (!held_valid[use_list[p]]) begin
                chosen = p;
            end
        end
        phys                = use_list[chosen];
        res.slot            = phys;
        res.fetch           = 1'b1;
        res.device_address  = ADDR_BITS'(sector) + ADDR_BITS'(read_offset);
        if (read_ok) begin
            held_tag[phys]   = sector;
            held_valid[phys] = 1'b1;
            move_to_recent(chosen);
            res.status       = ST_FILLED;
        end else begin
            held_valid[phys] = 1'b0;
            res.status       = ST_FAILED;
        end
        return res;
    endfunction

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            failures++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_sector_result want;
        if (!i_rst_n) begin
            for (int s = 0; s < SLOTS; s++) begin
                use_list[s]   = SLOT_BITS'(s);
                held_tag[s]   = '0;
                held_valid[s] = 1'b0;
            end
            read_offset = READ_OFFSET_RESET;
            expected_results.delete();
        end else begin
            if (i_strobe) begin
                if (expected_results.size() == 0) begin
                    $display("%0t ns: result strobed with no request outstanding, status %0d",
                             $time, i_status);
                    failures++;
                end else begin
                    want = expected_results.pop_front();
                    compare_field("status", 32'(want.status), 32'(i_status));
                    compare_field("slot", 32'(want.slot), 32'(i_slot));
                    compare_field("fetch", 32'(want.fetch), 32'(i_fetch));
                    compare_field("device_address", 32'(want.device_address),
                                  32'(i_device_address));
                end
            end
            // A request taken at the same edge as an offset write still sees
            // the old offset.
            if (i_start && !i_busy) begin
                expected_results.push_back(look_up_sector(i_command, i_sector, i_read_ok));
            end
            if (i_cfg_valid && i_cfg_ready) begin
                read_offset = i_cfg_data;
            end
        end
        o_fail_count <= failures;
        o_pending    <= expected_results.size();
    end

endmodule

// ===== tb/lru_sector_cache_tags_unit_tb.sv =====
// ----------------------------------------------------------------------------
// lru_sector_cache_tags_unit_tb
// Drives clear and access requests into the sector cache tag unit under
// several read offsets and leaves the checking to the checker instance.
// ----------------------------------------------------------------------------
module lru_sector_cache_tags_unit_tb;
    import lsct_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD       = 12;
    localparam int RESET_CYCLES     = 4;
    localparam int PHASES           = 6;
    localparam int RANDOM_PER_PHASE = 200;
    localparam int QUIET_TAIL       = 150;
    localparam int POOL_SIZE        = 12;
    localparam int CYCLE_LIMIT      = 200000;

    logic                   i_clk            = 1'b0;
    logic                   i_rst_n          = 1'b0;
    logic                   start            = 1'b0;
    logic                   busy;
    logic                   i_command        = CMD_CLEAR;
    logic [SECTOR_BITS-1:0] i_sector         = '0;
    logic                   i_read_ok        = 1'b0;
    logic                   o_strobe;
    logic [STATUS_BITS-1:0] o_status;
    logic [SLOT_BITS-1:0]   o_slot;
    logic                   o_fetch;
    logic [ADDR_BITS-1:0]   o_device_address;
    logic                   i_cfg_valid      = 1'b0;
    logic                   o_cfg_ready;
    logic [OFFSET_BITS-1:0] i_cfg_data       = '0;

    int                     fail_count;
    int                     pending;
    int unsigned            cycle_count      = 0;
    int                     requests_sent    = 0;
    int                     clears_sent      = 0;
    int                     offsets_written  = 0;

    // Sectors that random accesses mostly draw from, so that hits, refills
    // of invalid slots and evictions of the least recently used slot all
    // turn up often.
    logic [SECTOR_BITS-1:0] sector_pool [POOL_SIZE];

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    lru_sector_cache_tags_unit uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_command        (i_command),
        .i_sector         (i_sector),
        .i_read_ok        (i_read_ok),
        .o_strobe         (o_strobe),
        .o_status         (o_status),
        .o_slot           (o_slot),
        .o_fetch          (o_fetch),
        .o_device_address (o_device_address),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    lru_sector_cache_tags_unit_checker checker_inst (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_busy           (busy),
        .i_command        (i_command),
        .i_sector         (i_sector),
        .i_read_ok        (i_read_ok),
        .i_strobe         (o_strobe),
        .i_status         (o_status),
        .i_slot           (o_slot),
        .i_fetch          (o_fetch),
        .i_device_address (o_device_address),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    // Safety net: a hung handshake or a result that never arrives ends the
    // run here rather than letting it spin for ever.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Run stopped at the cycle limit of %0d cycles.", CYCLE_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Present one request and hold it until the block takes it. Start is
    // left high, so a request that follows straight on keeps start high
    // without a glitch.
    task automatic send_request(logic command, logic [SECTOR_BITS-1:0] sector, logic read_ok);
        start     <= 1'b1;
        i_command <= command;
        i_sector  <= sector;
        i_read_ok <= read_ok;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        requests_sent++;
        if (command == CMD_CLEAR) begin
            clears_sent++;
        end
    endtask

    task automatic pause_sender(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Wait until every predicted result has been strobed out; each result is
    // registered behind its request.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_read_offset(logic [OFFSET_BITS-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        offsets_written++;
    endtask

    initial begin : stimulus
        logic                   command;
        logic                   read_ok;
        logic [SECTOR_BITS-1:0] sector;
        logic [OFFSET_BITS-1:0] offset;
        bit                     idle_on;
        bit                     quiet;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int phase = 0; phase < PHASES; phase++) begin
            // The first phase runs at the reset value of the read offset;
            // later phases change it only once the block has gone quiet.
            if (phase > 0) begin
                drain_results();
                case (phase)
                    1:       offset = 8'd0;
                    2:       offset = 8'd255;
                    3:       offset = OFFSET_BITS'($urandom_range(2, 254));
                    4:       offset = 8'd1;
                    default: offset = OFFSET_BITS'($urandom_range(255));
                endcase
                write_read_offset(offset);
            end

            if (phase == 0) begin
                // Lowest and highest sectors, a hit that ignores read_ok,
                // a failed fetch followed by a refill of the same slot.
                send_request(CMD_ACCESS, 24'h000000, 1'b1);
                send_request(CMD_ACCESS, 24'h000000, 1'b1);
                send_request(CMD_ACCESS, 24'hFFFFFF, 1'b1);
                send_request(CMD_ACCESS, 24'hFFFFFF, 1'b0);
                send_request(CMD_ACCESS, 24'h123456, 1'b0);
                send_request(CMD_ACCESS, 24'h123456, 1'b1);
                // Fill the remaining slots so that every slot is valid.
                for (int k = 1; k <= 5; k++) begin
                    send_request(CMD_ACCESS, SECTOR_BITS'(k), 1'b1);
                end
                // Promote the oldest entry, then evict the least recently
                // used slot on a miss.
                send_request(CMD_ACCESS, 24'h000000, 1'b0);
                send_request(CMD_ACCESS, 24'h000777, 1'b1);
                // A failed fetch with every slot valid invalidates the least
                // recently used slot; the next miss must pick that one.
                send_request(CMD_ACCESS, 24'hFFFFFF, 1'b0);
                send_request(CMD_ACCESS, 24'h000888, 1'b1);
                send_request(CMD_ACCESS, 24'h000888, 1'b1);
                // Clear with junk in the ignored fields, then miss into the
                // first invalid slot in list order.
                send_request(CMD_CLEAR, 24'hFFFFFF, 1'b1);
                send_request(CMD_ACCESS, 24'h000777, 1'b1);
                send_request(CMD_CLEAR, 24'h000000, 1'b0);
            end else if (phase == 2) begin
                // Largest device address and a failed fetch near the top.
                send_request(CMD_ACCESS, 24'hFFFFFF, 1'b1);
                send_request(CMD_ACCESS, 24'hFFFFFE, 1'b0);
                send_request(CMD_ACCESS, 24'hFFFFFF, 1'b1);
            end

            sector_pool[0] = '0;
            sector_pool[1] = '1;
            for (int k = 2; k < POOL_SIZE; k++) begin
                sector_pool[k] = SECTOR_BITS'($urandom);
            end

            idle_on = 1'b0;
            for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
                // Idling is switched on or off for runs of forty requests so
                // that back-to-back stretches alternate with gappy ones.
                if (i % 40 == 0) begin
                    idle_on = ($urandom_range(9) < 6);
                end
                command = ($urandom_range(99) < 4) ? CMD_CLEAR : CMD_ACCESS;
                if ($urandom_range(99) < 70) begin
                    sector = sector_pool[$urandom_range(POOL_SIZE - 1)];
                end else begin
                    sector = SECTOR_BITS'($urandom);
                end
                read_ok = ($urandom_range(99) < 85);
                send_request(command, sector, read_ok);
                quiet = (phase == PHASES - 1) && (i >= RANDOM_PER_PHASE - QUIET_TAIL);
                if (idle_on && !quiet && $urandom_range(3) == 0) begin
                    pause_sender($urandom_range(1, 7));
                end
            end
        end

        drain_results();

        $display("Summary: %0d requests driven, %0d of them clears, under %0d read offset writes",
                 requests_sent, clears_sent, offsets_written);
        $display("Summary: hits, fills, failed fetches and evictions checked field by field.");
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== lru_sector_cache_tags_unit.f =====
+incdir+design
design/lsct_pkg.sv
design/lsct_cell.sv
design/lru_sector_cache_tags_unit.sv
tb/lru_sector_cache_tags_unit_checker.sv
tb/lru_sector_cache_tags_unit_tb.sv
